@@ rtl/texture_nearest_sample_gamma_unit_defines.svh @@
// assertion macros shared by the checker of the texture sampling unit
// expects i_clk and i_rst_n in the scope of each use
`ifndef TEXTURE_NEAREST_SAMPLE_GAMMA_UNIT_DEFINES_SVH
`define TEXTURE_NEAREST_SAMPLE_GAMMA_UNIT_DEFINES_SVH

// implication checked outside reset
`define TNSG_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tnsg assertion failed");

// next-cycle implication, also checked during reset
`define TNSG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("tnsg assertion failed");

`endif

@@ rtl/tnsg_pkg.sv @@
// types, constants and elaboration-time tables of the texture sampling unit
// no dependencies
`default_nettype none

package tnsg_pkg;

    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SAMPLE = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        CFG_TEX_WIDTH  = 2'd0,
        CFG_TEX_HEIGHT = 2'd1,
        CFG_GAMMA_EXP  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_req_type          req_type;
        logic [7:0]         texel_col;
        logic [7:0]         texel_row;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } t_req;

    typedef struct packed {
        logic [15:0] lin_red;
        logic [15:0] lin_green;
        logic [15:0] lin_blue;
    } t_res;

    // item travelling beside the coordinate pipelines
    typedef struct packed {
        logic        is_load;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [23:0] texel;
    } t_slot;

    localparam int SIZE_W      = 9;
    localparam int GAMMA_W     = 15;
    localparam int CHAN_W      = 8;
    localparam int TEXEL_W     = 3 * CHAN_W;
    localparam int LIN_W       = 16;
    localparam int NL_W        = 19;
    localparam int Y_W         = NL_W + GAMMA_W - 12;
    localparam int M_W         = 33;
    localparam int FAC_W       = 32;
    localparam int MAG_W       = 24;
    localparam int EXP_STEPS   = 16;
    localparam int REM_PER_STG = 4;
    localparam int REM_STAGES  = MAG_W / REM_PER_STG;
    localparam int WRAP_LAT    = REM_STAGES + 3;
    localparam int RAM_LAT     = 1;
    localparam int DEC_LAT     = EXP_STEPS + 3;
    localparam int TOTAL_LAT   = WRAP_LAT + RAM_LAT + DEC_LAT;

    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 9'd256;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = 15'd9011;
    localparam logic [CHAN_W-1:0]  CHAN_FULL   = 8'd255;

    typedef logic [EXP_STEPS-1:0][FAC_W-1:0] t_fac_tab;
    typedef logic [255:0][NL_W-1:0]          t_nl_tab;

    // floor square root, one result bit per step
    function automatic logic [63:0] isqrt64(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = x;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // factors 2^32 * 2^(-2^-(i+1)) by repeated square roots
    function automatic t_fac_tab build_factors();
        t_fac_tab    tab;
        logic [63:0] p;
        p      = isqrt64(64'd1 << 63);
        tab[0] = p[FAC_W-1:0];
        for (int i = 1; i < EXP_STEPS; i++) begin
            p      = isqrt64({p[31:0], 32'd0});
            tab[i] = p[FAC_W-1:0];
        end
        return tab;
    endfunction

    // -log2(c/255) in Q3.16 by normalize and repeated squaring
    function automatic logic [NL_W-1:0] neg_log2(input logic [CHAN_W-1:0] c);
        logic [63:0] x;
        logic [63:0] r;
        logic [3:0]  e;
        logic [15:0] frac;
        logic [19:0] nl;
        if (c == '0) begin
            return '0;
        end
        // ratio c/255 in Q2.30: reciprocal (2^32 - 1) / 255, then one correction
        x = {56'd0, c} << 30;
        r = (x * 64'd16843009) >> 32;
        if ((r + 64'd1) * {56'd0, CHAN_FULL} <= x) begin
            r = r + 64'd1;
        end
        e = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (r < (64'd1 << 30)) begin
                r = r << 1;
                e = e + 4'd1;
            end
        end
        frac = 16'd0;
        for (int i = 0; i < 16; i++) begin
            r    = (r * r) >> 30;
            frac = {frac[14:0], 1'b0};
            if (r >= (64'd1 << 31)) begin
                r       = r >> 1;
                frac[0] = 1'b1;
            end
        end
        nl = {e, 16'd0} - {4'd0, frac};
        return nl[NL_W-1:0];
    endfunction

    function automatic t_nl_tab build_nl_tab();
        t_nl_tab tab;
        for (int c = 0; c < 256; c++) begin
            tab[c] = neg_log2(8'(c));
        end
        return tab;
    endfunction

    localparam t_fac_tab EXP_FACTOR = build_factors();
    localparam t_nl_tab  NEG_LOG2   = build_nl_tab();

endpackage

`default_nettype wire

@@ rtl/tnsg_ram.sv @@
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module tnsg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/tnsg_wrap.sv @@
// coordinate to texel index: scale, truncate, repeat-wrap, optional flip
// depends on tnsg_pkg
`default_nettype none

module tnsg_wrap (
    input  wire logic                              i_clk,
    input  wire logic signed [31:0]                i_coord,
    input  wire logic [tnsg_pkg::SIZE_W-1:0]       i_size,
    input  wire logic                              i_flip,
    output logic      [tnsg_pkg::SIZE_W-1:0]       o_index
);

    localparam int SW = tnsg_pkg::SIZE_W;
    localparam int MW = tnsg_pkg::MAG_W;
    localparam int NS = tnsg_pkg::REM_STAGES;
    localparam int PW = 32 + SW + 1;

    logic signed [SW:0]   w_scale;
    logic signed [PW-1:0] r_prod;
    logic [PW-1:0]        w_abs;
    logic [MW-1:0]        r_mag;
    logic                 r_neg;
    logic [SW-1:0]        r_rem  [NS];
    logic [MW-1:0]        r_bits [NS];
    logic                 r_sgn  [NS];
    logic [SW-1:0]        w_idx;
    logic [SW-1:0]        r_index;

    // scale by size minus one
    assign w_scale = $signed({1'b0, i_size - {{(SW-1){1'b0}}, 1'b1}});

    always_ff @(posedge i_clk) begin
        r_prod <= i_coord * w_scale;
    end

    // magnitude of the product truncated toward zero
    assign w_abs = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);

    always_ff @(posedge i_clk) begin
        r_mag <= w_abs[MW+15:16];
        r_neg <= r_prod[PW-1];
    end

    // restoring remainder, a few bits per stage
    for (genvar k = 0; k < NS; k++) begin : g_rem
        logic [SW-1:0] w_rem_in;
        logic [MW-1:0] w_bits_in;
        logic          w_sgn_in;
        logic [SW-1:0] w_rem_out;
        logic [MW-1:0] w_bits_out;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_bits_in = r_mag;
            assign w_sgn_in  = r_neg;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_bits_in = r_bits[k-1];
            assign w_sgn_in  = r_sgn[k-1];
        end

        always_comb begin
            logic [SW:0]   t;
            logic [SW-1:0] rem;
            logic [MW-1:0] bits;
            rem  = w_rem_in;
            bits = w_bits_in;
            for (int j = 0; j < tnsg_pkg::REM_PER_STG; j++) begin
                t    = {rem, bits[MW-1]};
                bits = {bits[MW-2:0], 1'b0};
                if (t >= {1'b0, i_size}) begin
                    t = t - {1'b0, i_size};
                end
                rem = t[SW-1:0];
            end
            w_rem_out  = rem;
            w_bits_out = bits;
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= w_rem_out;
            r_bits[k] <= w_bits_out;
            r_sgn[k]  <= w_sgn_in;
        end
    end

    // negative remainder folds back into range, then optional flip
    always_comb begin
        logic [SW-1:0] idx;
        idx = (r_sgn[NS-1] && r_rem[NS-1] != '0) ? i_size - r_rem[NS-1] : r_rem[NS-1];
        w_idx = i_flip ? i_size - {{(SW-1){1'b0}}, 1'b1} - idx : idx;
    end

    always_ff @(posedge i_clk) begin
        r_index <= w_idx;
    end

    assign o_index = r_index;

endmodule

`default_nettype wire

@@ rtl/tnsg_decode.sv @@
// gamma decode of one 8-bit channel into Q0.16: log table, scale, exp chain
// depends on tnsg_pkg
`default_nettype none

module tnsg_decode (
    input  wire logic                               i_clk,
    input  wire logic [tnsg_pkg::CHAN_W-1:0]        i_chan,
    input  wire logic [tnsg_pkg::GAMMA_W-1:0]       i_gamma,
    output logic      [tnsg_pkg::LIN_W-1:0]         o_lin
);

    localparam int NW = tnsg_pkg::NL_W;
    localparam int GW = tnsg_pkg::GAMMA_W;
    localparam int YW = tnsg_pkg::Y_W;
    localparam int MW = tnsg_pkg::M_W;
    localparam int FW = tnsg_pkg::FAC_W;
    localparam int NE = tnsg_pkg::EXP_STEPS;

    logic [NW-1:0]    r_nl;
    logic             r_zero1;
    logic [NW+GW-1:0] w_scaled;
    logic [YW-1:0]    r_y;
    logic             r_zero2;
    logic [MW-1:0]    r_m    [NE];
    logic [5:0]       r_n    [NE];
    logic [15:0]      r_f    [NE];
    logic             r_zero [NE];
    logic [15:0]      n_out;
    logic [15:0]      r_out;

    // log lookup
    always_ff @(posedge i_clk) begin
        r_nl    <= tnsg_pkg::NEG_LOG2[i_chan];
        r_zero1 <= (i_chan == '0);
    end

    // scale by the gamma exponent
    assign w_scaled = {{GW{1'b0}}, r_nl} * {{NW{1'b0}}, i_gamma};

    always_ff @(posedge i_clk) begin
        r_y     <= w_scaled[NW+GW-1:12];
        r_zero2 <= r_zero1;
    end

    // one factor per fraction bit
    for (genvar k = 0; k < NE; k++) begin : g_exp
        logic [MW-1:0]    w_m_in;
        logic [5:0]       w_n_in;
        logic [15:0]      w_f_in;
        logic             w_zero_in;
        logic [MW+FW-1:0] w_prod;

        if (k == 0) begin : g_first
            assign w_m_in    = {1'b1, {(MW-1){1'b0}}};
            assign w_n_in    = r_y[YW-1:16];
            assign w_f_in    = r_y[15:0];
            assign w_zero_in = r_zero2;
        end else begin : g_next
            assign w_m_in    = r_m[k-1];
            assign w_n_in    = r_n[k-1];
            assign w_f_in    = r_f[k-1];
            assign w_zero_in = r_zero[k-1];
        end

        assign w_prod = {{FW{1'b0}}, w_m_in} * {{MW{1'b0}}, tnsg_pkg::EXP_FACTOR[k]};

        always_ff @(posedge i_clk) begin
            r_m[k]    <= w_f_in[15-k] ? w_prod[MW+FW-1:FW] : w_m_in;
            r_n[k]    <= w_n_in;
            r_f[k]    <= w_f_in;
            r_zero[k] <= w_zero_in;
        end
    end

    // integer shift, round, saturate, zero channel
    always_comb begin
        logic [MW-1:0] v;
        logic [MW:0]   sum;
        v   = (r_n[NE-1] >= 6'd40) ? '0 : (r_m[NE-1] >> r_n[NE-1]);
        sum = {1'b0, v} + (MW+1)'(32768);
        if (r_zero[NE-1]) begin
            n_out = (i_gamma == '0) ? 16'hFFFF : 16'h0000;
        end else if (sum[MW:16] > (MW-15)'(16'hFFFF)) begin
            n_out = 16'hFFFF;
        end else begin
            n_out = sum[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_lin = r_out;

endmodule

`default_nettype wire

@@ rtl/texture_nearest_sample_gamma_unit.sv @@
// Texture sampling unit with repeat wrap and gamma decode.
// Depends on tnsg_pkg, tnsg_wrap, tnsg_decode and tnsg_ram.
//
// Usage:
//   Input items arrive on i_req and transfer at a clock edge with start high
//   and busy low. busy is always low: one item can transfer every cycle.
//   A load item (req_type load) writes one RGB texel into the texel memory if
//   its column and row fall inside the configured size, and gives no result.
//   A sample item gives one result on o_res, marked by o_valid for one cycle,
//   after coordinate scaling and wrap (one multiply, then a remainder unit
//   taking four bits per stage), a registered texel memory read, and gamma
//   decode (log lookup, one multiply by the exponent, then 16 stages of one
//   multiply each).
//   Sustained rate is one item per cycle; loads and samples keep their order.
//   Configuration writes (width, height, gamma) take effect at once through
//   i_cfg_we / i_cfg_idx / i_cfg_data and must happen only while idle.
//   Reset (synchronous, active low) clears all valid bits and restores the
//   register defaults; the texel memory is not cleared, and a sample of a
//   texel never loaded returns unspecified data.
//   The receiver cannot stall: results must be taken when o_valid is high.
`default_nettype none

module texture_nearest_sample_gamma_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire tnsg_pkg::t_req                      i_req,
    output logic                                     o_valid,
    output tnsg_pkg::t_res                           o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [1:0]                          i_cfg_idx,
    input  wire logic [tnsg_pkg::GAMMA_W-1:0]        i_cfg_data
);

    localparam int SW    = tnsg_pkg::SIZE_W;
    localparam int CW    = tnsg_pkg::CHAN_W;
    localparam int WL    = tnsg_pkg::WRAP_LAT;
    localparam int DL    = tnsg_pkg::DEC_LAT;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    logic [SW-1:0]                r_tex_width;
    logic [SW-1:0]                r_tex_height;
    logic [tnsg_pkg::GAMMA_W-1:0] r_gamma_exp;
    logic [SW-1:0]                w_eff_w;
    logic [SW-1:0]                w_eff_h;
    logic                         w_accept;
    logic                         r_vld  [WL];
    tnsg_pkg::t_slot              r_slot [WL];
    logic [SW-1:0]                w_col_idx;
    logic [SW-1:0]                w_row_idx;
    tnsg_pkg::t_slot              w_tail;
    logic                         w_tail_vld;
    logic                         w_we;
    logic [AW-1:0]                w_addr;
    logic [tnsg_pkg::TEXEL_W-1:0] w_rdata;
    logic                         r_rd_vld;
    logic                         r_dec_vld [DL];

    // pipeline never holds off the sender
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= tnsg_pkg::SIZE_RESET;
            r_tex_height <= tnsg_pkg::SIZE_RESET;
            r_gamma_exp  <= tnsg_pkg::GAMMA_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tnsg_pkg::CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data[SW-1:0];
                tnsg_pkg::CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data[SW-1:0];
                tnsg_pkg::CFG_GAMMA_EXP:  r_gamma_exp  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective sizes, zero acts as one, clamp to the memory size
    always_comb begin
        if (r_tex_width == '0) begin
            w_eff_w = SW'(1);
        end else if (int'(r_tex_width) > MAX_WIDTH) begin
            w_eff_w = SW'(MAX_WIDTH);
        end else begin
            w_eff_w = r_tex_width;
        end
        if (r_tex_height == '0) begin
            w_eff_h = SW'(1);
        end else if (int'(r_tex_height) > MAX_HEIGHT) begin
            w_eff_h = SW'(MAX_HEIGHT);
        end else begin
            w_eff_h = r_tex_height;
        end
    end

    // coordinate pipelines
    tnsg_wrap u_wrap_u (
        .i_clk   (i_clk),
        .i_coord (i_req.coord_u),
        .i_size  (w_eff_w),
        .i_flip  (1'b0),
        .o_index (w_col_idx)
    );

    tnsg_wrap u_wrap_v (
        .i_clk   (i_clk),
        .i_coord (i_req.coord_v),
        .i_size  (w_eff_h),
        .i_flip  (1'b1),
        .o_index (w_row_idx)
    );

    // item slots alongside the coordinate pipelines
    for (genvar k = 0; k < WL; k++) begin : g_slot
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= w_accept;
                end
            end

            always_ff @(posedge i_clk) begin
                r_slot[k].is_load <= (i_req.req_type == tnsg_pkg::REQ_LOAD);
                r_slot[k].col     <= i_req.texel_col;
                r_slot[k].row     <= i_req.texel_row;
                r_slot[k].texel   <= {i_req.in_red, i_req.in_green, i_req.in_blue};
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                r_slot[k] <= r_slot[k-1];
            end
        end
    end

    assign w_tail     = r_slot[WL-1];
    assign w_tail_vld = r_vld[WL-1];

    // memory access, write for in-range loads, read for samples
    always_comb begin
        w_we = w_tail_vld && w_tail.is_load
               && ({1'b0, w_tail.col} < w_eff_w) && ({1'b0, w_tail.row} < w_eff_h);
        if (w_tail.is_load) begin
            w_addr = AW'(32'(w_tail.row) * MAX_WIDTH + 32'(w_tail.col));
        end else begin
            w_addr = AW'(32'(w_row_idx) * MAX_WIDTH + 32'(w_col_idx));
        end
    end

    tnsg_ram #(
        .WIDTH (tnsg_pkg::TEXEL_W),
        .DEPTH (DEPTH)
    ) u_texels (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_addr),
        .i_wdata (w_tail.texel),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_tail_vld && !w_tail.is_load;
        end
    end

    // per-channel gamma decode
    tnsg_decode u_dec_red (
        .i_clk   (i_clk),
        .i_chan  (w_rdata[3*CW-1:2*CW]),
        .i_gamma (r_gamma_exp),
        .o_lin   (o_res.lin_red)
    );

    tnsg_decode u_dec_green (
        .i_clk   (i_clk),
        .i_chan  (w_rdata[2*CW-1:CW]),
        .i_gamma (r_gamma_exp),
        .o_lin   (o_res.lin_green)
    );

    tnsg_decode u_dec_blue (
        .i_clk   (i_clk),
        .i_chan  (w_rdata[CW-1:0]),
        .i_gamma (r_gamma_exp),
        .o_lin   (o_res.lin_blue)
    );

    // result strobe follows the decode stages
    for (genvar k = 0; k < DL; k++) begin : g_dvld
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dec_vld[k] <= 1'b0;
                end else begin
                    r_dec_vld[k] <= r_rd_vld;
                end
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dec_vld[k] <= 1'b0;
                end else begin
                    r_dec_vld[k] <= r_dec_vld[k-1];
                end
            end
        end
    end

    assign o_valid = r_dec_vld[DL-1];

endmodule

`default_nettype wire

@@ rtl/tnsg_checker.sv @@
// port-level checks of the texture sampling unit, bound to its top level
// depends on tnsg_pkg and the assertion macro header
`default_nettype none

`include "texture_nearest_sample_gamma_unit_defines.svh"

module tnsg_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_start,
    input wire logic           i_busy,
    input wire tnsg_pkg::t_req i_req,
    input wire logic           i_valid
);

    // every result comes from a sample transfer a fixed latency earlier
    `TNSG_ASSERT_IMP(a_result_has_sample, i_valid, $past(i_start && !i_busy && i_req.req_type == tnsg_pkg::REQ_SAMPLE, tnsg_pkg::TOTAL_LAT))

    // reset empties the pipeline
    `TNSG_ASSERT_NEXT(a_reset_clears, !i_rst_n, !i_valid)

    // input side is never held off
    `TNSG_ASSERT_IMP(a_never_busy, 1'b1, !i_busy)

endmodule

bind texture_nearest_sample_gamma_unit tnsg_checker u_tnsg_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (start),
    .i_busy  (busy),
    .i_req   (i_req),
    .i_valid (o_valid)
);

`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench of texture_nearest_sample_gamma_unit
// depends on tnsg_pkg and the unit; predicts texel fetch, wrap and gamma decode
`timescale 1ns / 100ps

module tb;

    localparam int               DIM        = 256;
    localparam int               DRAIN_WAIT = tnsg_pkg::TOTAL_LAT + 8;
    localparam logic [1:0]       CFG_SPARE  = 2'd3;   // index past the register list

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    tnsg_pkg::t_req                 i_req;
    logic                           o_valid;
    tnsg_pkg::t_res                 o_res;
    logic                           i_cfg_we;
    logic [1:0]                     i_cfg_idx;
    logic [tnsg_pkg::GAMMA_W-1:0]   i_cfg_data;

    texture_nearest_sample_gamma_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the unit's registers and texel memory
    logic [8:0]       size_w_reg;
    logic [8:0]       size_h_reg;
    logic [14:0]      gamma_reg;
    logic [23:0]      texel_mem [DIM*DIM];
    bit               texel_loaded [DIM*DIM];
    logic [63:0]      half_pow [16];
    logic [15:0]      lin_of_byte [256];
    tnsg_pkg::t_res   lin_due [$];

    int               errors;
    int               samples_checked;
    int               loads_sent;
    int               cfg_writes;
    int               burst_left;
    bit               gaps_on;
    logic             busy_seen;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // outputs and busy are stable mid-cycle, sample there
    always @(negedge i_clk) begin
        busy_seen = busy;
    end

    // floor square root, one result bit at a time
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] acc;
        logic [63:0] trial;
        acc = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= x) begin
                acc = trial;
            end
        end
        return acc;
    endfunction

    // (c/255)^g in Q0.16, g unsigned Q3.12
    function automatic logic [15:0] gamma_lin(input logic [7:0] c, input logic [14:0] g);
        logic [63:0] ratio;
        logic [63:0] nlog;
        logic [63:0] scaled;
        logic [63:0] mant;
        logic [63:0] shifted;
        logic [63:0] rounded;
        logic [15:0] frac;
        logic [15:0] fpart;
        int          shifts;
        int          ipart;
        if (c == 0) begin
            return (g == 0) ? 16'hFFFF : 16'h0000;
        end
        ratio  = (64'(c) << 30) / 64'd255;
        shifts = 0;
        while (ratio < (64'd1 << 30)) begin
            ratio  = ratio << 1;
            shifts = shifts + 1;
        end
        // each squaring yields one fraction bit of the log
        frac = '0;
        for (int i = 0; i < 16; i++) begin
            ratio = (ratio * ratio) >> 30;
            frac  = frac << 1;
            if (ratio >= (64'd1 << 31)) begin
                ratio   = ratio >> 1;
                frac[0] = 1'b1;
            end
        end
        nlog   = (64'(shifts) << 16) - 64'(frac);
        scaled = (nlog * 64'(g)) >> 12;
        ipart  = int'(scaled >> 16);
        fpart  = scaled[15:0];
        mant   = 64'd1 << 32;
        for (int i = 0; i < 16; i++) begin
            if (fpart[15-i]) begin
                mant = (mant * half_pow[i]) >> 32;
            end
        end
        shifted = (ipart >= 40) ? 64'd0 : (mant >> ipart);
        rounded = (shifted + 64'd32768) >> 16;
        return (rounded > 64'd65535) ? 16'hFFFF : rounded[15:0];
    endfunction

    function automatic int unsigned clamp_size(input logic [8:0] r);
        if (r == 0) begin
            return 1;
        end
        return (r > DIM) ? DIM : int'(r);
    endfunction

    // repeat wrap of one Q16.16 coordinate
    function automatic int unsigned wrap_coord(input logic signed [31:0] c,
                                               input int unsigned size);
        longint q;
        q = (longint'(c) * longint'(size - 1)) / 64'sd65536;
        q = q % longint'(size);
        if (q < 0) begin
            q = q + longint'(size);
        end
        return int'(q);
    endfunction

    function automatic int texel_addr(input logic signed [31:0] u, input logic signed [31:0] v);
        int unsigned w;
        int unsigned h;
        w = clamp_size(size_w_reg);
        h = clamp_size(size_h_reg);
        return (int'(h) - 1 - int'(wrap_coord(v, h))) * DIM + int'(wrap_coord(u, w));
    endfunction

    // result check, one result per strobe
    always @(negedge i_clk) begin
        tnsg_pkg::t_res want;
        if (i_rst_n && o_valid) begin
            if (lin_due.size() == 0) begin
                $error("result with nothing expected: %h", o_res);
                errors++;
            end else begin
                want = lin_due.pop_front();
                samples_checked++;
                if (o_res.lin_red !== want.lin_red) begin
                    $error("lin_red expected %h actual %h", want.lin_red, o_res.lin_red);
                    errors++;
                end
                if (o_res.lin_green !== want.lin_green) begin
                    $error("lin_green expected %h actual %h", want.lin_green, o_res.lin_green);
                    errors++;
                end
                if (o_res.lin_blue !== want.lin_blue) begin
                    $error("lin_blue expected %h actual %h", want.lin_blue, o_res.lin_blue);
                    errors++;
                end
            end
        end
    end

    // one transfer, prediction updated when it is taken
    task automatic send_item(input tnsg_pkg::t_req req);
        tnsg_pkg::t_res res;
        int             addr;
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy_seen) begin
            @(posedge i_clk);
        end
        if (req.req_type == tnsg_pkg::REQ_LOAD) begin
            loads_sent++;
            if (req.texel_col < clamp_size(size_w_reg) && req.texel_row < clamp_size(size_h_reg))
            begin
                addr = int'(req.texel_row) * DIM + int'(req.texel_col);
                texel_mem[addr]    = {req.in_red, req.in_green, req.in_blue};
                texel_loaded[addr] = 1'b1;
            end
        end else begin
            addr          = texel_addr(req.coord_u, req.coord_v);
            res.lin_red   = lin_of_byte[texel_mem[addr][23:16]];
            res.lin_green = lin_of_byte[texel_mem[addr][15:8]];
            res.lin_blue  = lin_of_byte[texel_mem[addr][7:0]];
            lin_due.push_back(res);
        end
        // bursty sender
        if (gaps_on) begin
            if (burst_left == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    function automatic tnsg_pkg::t_req noise_req();
        tnsg_pkg::t_req req;
        logic [127:0]   raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        req = raw[$bits(tnsg_pkg::t_req)-1:0];
        return req;
    endfunction

    // sample (u, v); loads the target texel first when never loaded or when forced
    task automatic sample_at(input logic signed [31:0] u, input logic signed [31:0] v,
                             input bit force_load, input logic [23:0] rgb);
        tnsg_pkg::t_req req;
        int             addr;
        addr = texel_addr(u, v);
        if (force_load || !texel_loaded[addr]) begin
            req           = noise_req();
            req.req_type  = tnsg_pkg::REQ_LOAD;
            req.texel_col = 8'(addr % DIM);
            req.texel_row = 8'(addr / DIM);
            {req.in_red, req.in_green, req.in_blue} = rgb;
            send_item(req);
        end
        req          = noise_req();
        req.req_type = tnsg_pkg::REQ_SAMPLE;
        req.coord_u  = u;
        req.coord_v  = v;
        send_item(req);
    endtask

    // wait until nothing is in flight, loads included
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (lin_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic cfg_write(input logic [1:0] idx, input logic [tnsg_pkg::GAMMA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            tnsg_pkg::CFG_TEX_WIDTH:  size_w_reg = data[8:0];
            tnsg_pkg::CFG_TEX_HEIGHT: size_h_reg = data[8:0];
            tnsg_pkg::CFG_GAMMA_EXP: begin
                gamma_reg = data;
                for (int c = 0; c < 256; c++) begin
                    lin_of_byte[c] = gamma_lin(8'(c), gamma_reg);
                end
            end
            default: ;
        endcase
    endtask

    task automatic set_phase(input logic [8:0] w, input logic [8:0] h, input logic [14:0] g);
        drain();
        cfg_write(tnsg_pkg::CFG_TEX_WIDTH, tnsg_pkg::GAMMA_W'(w));
        cfg_write(tnsg_pkg::CFG_TEX_HEIGHT, tnsg_pkg::GAMMA_W'(h));
        cfg_write(tnsg_pkg::CFG_GAMMA_EXP, g);
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 1)) begin
            return $urandom;
        end
        return $signed($urandom_range(0, 32'h80000)) - 32'sh40000;
    endfunction

    // extremes of coordinates and channels at reset settings
    task automatic test_directed_defaults();
        sample_at(32'sd0, 32'sd0, 1'b1, 24'h00FF01);
        sample_at(32'sh7FFFFFFF, 32'sh80000000, 1'b1, 24'hFF0080);
        sample_at(32'sh80000000, 32'sh7FFFFFFF, 1'b1, 24'h01FE00);
        sample_at(-32'sd1, 32'sh00010000, 1'b1, 24'hAA5533);
        sample_at(32'sh00010000, -32'sh00010000, 1'b1, 24'h7F807F);
        sample_at(32'sh00008000, 32'sh0000FFFF, 1'b0, 24'h000000);
    endtask

    // gamma extremes, zero channel with gamma zero, tiny channels at top gamma
    task automatic test_gamma_extremes();
        set_phase(9'd256, 9'd256, 15'd0);
        sample_at(32'sd0, 32'sd0, 1'b1, 24'h00FF01);
        set_phase(9'd256, 9'd256, 15'h7FFF);
        sample_at(32'sd0, 32'sd0, 1'b1, 24'h010280);
        sample_at(32'sh12345678, 32'sh9ABCDEF0, 1'b1, 24'hFF00FE);
        set_phase(9'd256, 9'd256, 15'd4096);
        sample_at(32'sd0, 32'sd0, 1'b1, 24'h408020);
    endtask

    // sizes of zero, which acts as one, and over the maximum; loads outside the size
    task automatic test_size_edges();
        tnsg_pkg::t_req req;
        set_phase(9'd0, 9'h1FF, 15'd9011);
        sample_at(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b1, 24'h123456);
        set_phase(9'd3, 9'd2, 15'd9011);
        req           = noise_req();
        req.req_type  = tnsg_pkg::REQ_LOAD;
        req.texel_col = 8'd3;
        req.texel_row = 8'd0;
        send_item(req);
        req.texel_col = 8'd0;
        req.texel_row = 8'd2;
        send_item(req);
        sample_at(32'sh00018000, -32'sh00030000, 1'b0, 24'h0);
        drain();
        cfg_write(CFG_SPARE, 15'h7FFF);
        sample_at(32'sh00020000, 32'sh00010000, 1'b1, 24'hFFFFFF);
    endtask

    // random mix under one setting
    task automatic run_random(input int count);
        tnsg_pkg::t_req req;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) < 2) begin
                req = noise_req();
                if (req.req_type == tnsg_pkg::REQ_SAMPLE
                    && !texel_loaded[texel_addr(req.coord_u, req.coord_v)]) begin
                    req.req_type = tnsg_pkg::REQ_LOAD;
                end
                send_item(req);
            end else begin
                sample_at(rand_coord(), rand_coord(), $urandom_range(0, 3) == 0,
                          24'($urandom));
            end
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= tnsg_pkg::CFG_TEX_WIDTH;
        i_cfg_data <= '0;
        errors          = 0;
        samples_checked = 0;
        loads_sent      = 0;
        cfg_writes      = 0;
        burst_left      = 0;
        gaps_on         = 1'b0;
        size_w_reg      = tnsg_pkg::SIZE_RESET;
        size_h_reg      = tnsg_pkg::SIZE_RESET;
        gamma_reg       = tnsg_pkg::GAMMA_RESET;
        half_pow[0] = floor_root(64'd1 << 63);
        for (int i = 1; i < 16; i++) begin
            half_pow[i] = floor_root(half_pow[i-1] << 32);
        end
        for (int c = 0; c < 256; c++) begin
            lin_of_byte[c] = gamma_lin(8'(c), gamma_reg);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_defaults();
        test_gamma_extremes();
        test_size_edges();

        gaps_on = 1'b1;
        set_phase(9'd256, 9'd256, 15'd9011);
        run_random(180);
        // hold off until every result is back, then carry on
        drain();
        gaps_on = 1'b0;
        run_random(90);
        gaps_on = 1'b1;
        set_phase(9'd1, 9'd1, 15'h7FFF);
        run_random(60);
        set_phase(9'd37, 9'd200, 15'd0);
        run_random(150);
        set_phase(9'h12C, 9'd5, 15'd4096);
        run_random(150);
        set_phase(9'($urandom_range(1, 511)), 9'($urandom_range(1, 511)),
                  15'($urandom_range(0, 32767)));
        run_random(180);
        set_phase(9'd256, 9'd256, 15'($urandom_range(0, 32767)));
        gaps_on = 1'b0;
        run_random(120);
        drain();

        $display("checked %0d samples after %0d loads and %0d register writes",
                 samples_checked, loads_sent, cfg_writes);
        $display("sizes 0 to 511, gamma 0 to max, wrapped coordinates, bursty input");
        if (errors == 0 && lin_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tnsg_pkg.sv
rtl/tnsg_ram.sv
rtl/tnsg_wrap.sv
rtl/tnsg_decode.sv
rtl/texture_nearest_sample_gamma_unit.sv
rtl/tnsg_checker.sv
tb/tb.sv
